// ===== hw/rtl/oale_pkg.sv =====
// shared constants and field layout for the ordered array list engine
package oale_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RVAL_W   = 32;
    localparam int FPOS_W   = 7;
    localparam int CNT_W    = 7;

    localparam int IN_BITS  = CMD_W + POS_W + VALUE_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + RVAL_W + FPOS_W + CNT_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PRED   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SUCC   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

// ===== hw/rtl/ordered_array_list_engine.sv =====
// ordered array list engine: fixed-capacity list in a synchronous memory
// get reads a single entry; insert, delete and the searches walk the stored entries,
//   one memory entry walked per cycle
// throughput: one command at a time, the walk over the single read port sets the rate
// a result beat may wait in the output register while the next command is accepted
// reset: asynchronous, active low; count cleared, memory contents undefined until written
module ordered_array_list_engine
    import oale_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // command, position, value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, result_value, found_position, count_now, is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int EW = ELEMENT_WIDTH;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_PUT, S_FIN} state_t;

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rdata_reg;

    state_t              state_reg, state_next;
    logic                iss_reg, iss_next;
    logic                rv_reg, rv_next;
    logic                found_reg, found_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [AW-1:0]       ridx_reg, ridx_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       end_reg, end_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [EW-1:0]       val_reg, val_next;
    logic [EW-1:0]       prev_reg, prev_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [EW-1:0]       res_val_reg, res_val_next;
    logic [CW-1:0]       res_fpos_reg, res_fpos_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic [AW-1:0]       rd_addr;

    logic [CMD_W-1:0]    in_cmd;
    logic [POS_W-1:0]    in_pos;
    logic [63:0]         in_val64;
    logic [PW-1:0]       pos_w;
    logic [PW-1:0]       cnt_w;
    logic [PW-1:0]       pos_dec;
    logic                ins_ok;
    logic                acc_ok;
    logic [CW-1:0]       cnt_dec;
    logic [AW-1:0]       last_idx;
    logic [63:0]         rval64;
    logic [31:0]         fpos32;
    logic [31:0]         cnt32;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_pos   = s_tdata[CMD_W +: POS_W];
    assign in_val64 = {32'b0, s_tdata[CMD_W+POS_W +: VALUE_W]};
    assign pos_w    = PW'(in_pos);
    assign cnt_w    = PW'(count_reg);
    assign pos_dec  = pos_w - PW'(1);
    assign ins_ok   = (in_pos != '0) && (pos_w <= cnt_w + PW'(1));
    assign acc_ok   = (in_pos != '0) && (pos_w <= cnt_w);
    assign cnt_dec  = count_reg - CW'(1);
    assign last_idx = cnt_dec[AW-1:0];
    assign rval64   = 64'(res_val_reg);
    assign fpos32   = 32'(res_fpos_reg);
    assign cnt32    = 32'(count_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next      = state_reg;
        iss_next        = iss_reg;
        rv_next         = 1'b0;
        found_next      = found_reg;
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        ridx_next       = ridx_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        res_fpos_next   = res_fpos_reg;
        m_tdata_next    = m_tdata_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = val_reg;
        rd_addr         = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next        = in_cmd;
                    val_next        = in_val64[EW-1:0];
                    idx_next        = pos_dec[AW-1:0];
                    res_status_next = ST_OK;
                    res_val_next    = '0;
                    res_fpos_next   = '0;
                    found_next      = 1'b0;
                    iss_next        = 1'b1;
                    state_next      = S_FIN;
                    case (in_cmd)
                        CMD_INSERT:
                        begin
                            if (!ins_ok)
                                res_status_next = ST_BAD_POS;
                            else if (count_reg == CW'(CAPACITY))
                                res_status_next = ST_FULL;
                            else if (pos_dec == cnt_w)
                                state_next = S_PUT;
                            else
                            begin
                                ptr_next   = last_idx;
                                end_next   = pos_dec[AW-1:0];
                                state_next = S_WALK;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (!acc_ok)
                                res_status_next = ST_BAD_POS;
                            else
                            begin
                                ptr_next   = pos_dec[AW-1:0];
                                end_next   = last_idx;
                                state_next = S_WALK;
                            end
                        end
                        CMD_GET:
                        begin
                            if (!acc_ok)
                                res_status_next = ST_BAD_POS;
                            else
                            begin
                                ptr_next   = pos_dec[AW-1:0];
                                end_next   = pos_dec[AW-1:0];
                                state_next = S_WALK;
                            end
                        end
                        CMD_LOCATE, CMD_PRED, CMD_SUCC:
                        begin
                            if (count_reg == '0)
                                res_status_next = ST_NOT_FOUND;
                            else
                            begin
                                ptr_next   = '0;
                                end_next   = last_idx;
                                state_next = S_WALK;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (iss_reg)
                begin
                    rv_next   = 1'b1;
                    ridx_next = ptr_reg;
                    if (ptr_reg == end_reg)
                        iss_next = 1'b0;
                    else if (cmd_reg == CMD_INSERT)
                        ptr_next = ptr_reg - AW'(1);
                    else
                        ptr_next = ptr_reg + AW'(1);
                end
                if (rv_reg)
                begin
                    prev_next = rdata_reg;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = ridx_reg + AW'(1);
                            wr_data = rdata_reg;
                            if (ridx_reg == idx_reg)
                                state_next = S_PUT;
                        end
                        CMD_DELETE:
                        begin
                            if (ridx_reg == idx_reg)
                                res_val_next = rdata_reg;
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = ridx_reg - AW'(1);
                                wr_data = rdata_reg;
                            end
                            if (ridx_reg == last_idx)
                            begin
                                count_next = cnt_dec;
                                state_next = S_FIN;
                            end
                        end
                        CMD_GET:
                        begin
                            res_val_next = rdata_reg;
                            state_next   = S_FIN;
                        end
                        CMD_LOCATE, CMD_PRED, CMD_SUCC:
                        begin
                            if (found_reg)
                            begin
                                res_val_next = rdata_reg;
                                state_next   = S_FIN;
                            end
                            else if (rdata_reg == val_reg)
                            begin
                                found_next = 1'b1;
                                if (cmd_reg == CMD_LOCATE)
                                begin
                                    res_fpos_next = CW'(ridx_reg) + CW'(1);
                                    state_next    = S_FIN;
                                end
                                else if (cmd_reg == CMD_PRED)
                                begin
                                    if (ridx_reg == '0)
                                        res_status_next = ST_NOT_FOUND;
                                    else
                                        res_val_next = prev_reg;
                                    state_next = S_FIN;
                                end
                                else if (ridx_reg == last_idx)
                                begin
                                    res_status_next = ST_NOT_FOUND;
                                    state_next      = S_FIN;
                                end
                            end
                            else if (ridx_reg == last_idx)
                            begin
                                res_status_next = ST_NOT_FOUND;
                                state_next      = S_FIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({(count_reg == '0), cnt32[CNT_W-1:0],
                        fpos32[FPOS_W-1:0], rval64[RVAL_W-1:0], res_status_reg});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            iss_reg      <= 1'b0;
            rv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_reg      <= iss_next;
            rv_reg       <= rv_next;
            found_reg    <= found_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg       <= ridx_next;
        ptr_reg        <= ptr_next;
        end_reg        <= end_next;
        idx_reg        <= idx_next;
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_val_reg    <= res_val_next;
        res_fpos_reg   <= res_fpos_next;
        m_tdata_reg    <= m_tdata_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && (state_reg == S_IDLE || state_reg == S_FIN)))
        else $error("memory write outside a command");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + CW'(1)
        || count_reg == $past(count_reg) - CW'(1) || count_reg == '0)
        else $error("entry count moved by more than one");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_FIN))
        else $error("result beat raised outside finish");

endmodule
